// ----- rtl/mrr_pkg.sv -----
// mrr_pkg: shared types, constants and codes of the multicast record reassembler
// no dependencies; imported by the interfaces, the top level and the bench
package mrr_pkg;

  localparam int unsigned BUFFER_BYTES = 512;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  // order of a record: up to 254 * 7 + 7
  localparam int unsigned ORDER_W      = 11;
  // byte addresses derived from an order, wide enough for 4096
  localparam int unsigned BADDR_W      = 13;
  // 1/3 as 683 / 2048, exact for dividends below 2048
  localparam int unsigned RECIP3       = 683;
  localparam int unsigned RECIP3_SH    = 11;

  localparam logic [2:0] HEADER_SLOT  = 3'd7;
  localparam logic [7:0] HEADER_GROUP = 8'd1;
  localparam logic [7:0] COUNT_MAX    = 8'd255;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_COMPLETE   = 2'd1,
    STAT_CHECK_FAIL = 2'd2,
    STAT_RANGE      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MERGE,
    ST_SCAN,
    ST_RDREQ,
    ST_RDCAP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rec_byte1;
    logic [7:0] rec_byte2;
    logic [7:0] rec_byte3;
    logic [7:0] group_len;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic       complete;
    logic [7:0] payload_bytes;
    logic [7:0] read_data;
  } out_item_t;

endpackage

// ----- rtl/mrr_if.sv -----
// mrr_if: valid/ready channels carrying one input beat and one result beat
// depends on mrr_pkg for the payload structs
interface mrr_in_if import mrr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrr_out_if import mrr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mrr_ram.sv -----
// mrr_ram: generic one-write one-read ram with registered read data
// no dependencies
module mrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/multicast_record_reassembler.sv -----
// multicast_record_reassembler: rebuilds a payload from 3-byte records
// depends on mrr_pkg, mrr_in_if, mrr_out_if and mrr_ram
//
//  channel | dir | beat contents                                        | handshake
//  in_i    | in  | cmd, rec_byte1..3, group_len, read_index             | valid/ready
//  out_o   | out | status, complete, payload_bytes, read_data           | valid/ready
//
// after reset a clearing pass zeroes the payload and map rams, one entry a cycle,
// over all BUFFER_BYTES (512) entries before the first beat is taken
// from one accepted beat to the next: a rejected record passes decode and response,
// a stored record decode, merge and response, and once a length is known also a
// scan that checks the received map entry by entry through its single read port
// a read command passes a request and a capture state through the payload ram read port
// one beat is worked on at a time; in_i is ready only when idle, and a finished
// result sits in the output register so a new beat can be taken while out_o stalls
module multicast_record_reassembler import mrr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mrr_in_if.sink       in_i,
  mrr_out_if.source    out_o
);

  // sequencer and control registers
  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    clr_q;
  logic [7:0]           scan_q;
  logic                 pend_q;
  logic                 done_q;
  logic [7:0]           hdr_q;
  logic [7:0]           bcnt_q;
  logic                 ovalid_q;

  // payload registers
  in_item_t             req_q;
  status_e              stat_q;
  logic [7:0]           rdat_q;
  logic [ADDR_W-1:0]    rmw_addr_q;
  logic [7:0]           nib_q;
  logic [7:0]           tot_q;
  out_item_t            odata_q;

  // ram controls
  logic                 pay_we;
  logic [ADDR_W-1:0]    pay_waddr;
  logic [7:0]           pay_wdata;
  logic [ADDR_W-1:0]    pay_raddr;
  logic [7:0]           pay_rdata;
  logic                 map_we;
  logic [ADDR_W-1:0]    map_waddr;
  logic                 map_wdata;
  logic [ADDR_W-1:0]    map_raddr;
  logic                 map_rdata;

  logic                 in_acc;
  logic                 out_free;

  // record decode
  logic [7:0]           rec_a;
  logic [3:0]           rec_b;
  logic [2:0]           slot;
  logic                 chk_ok;
  logic                 is_hdr;
  logic                 grp_neg;
  logic [11:0]          ord_raw;
  logic [ORDER_W-1:0]   order;
  logic [11:0]          ord_p1;
  logic [BADDR_W-1:0]   lo_addr;
  logic [BADDR_W-1:0]   hi_addr;
  logic                 range_ok;
  logic                 odd_ord;
  logic [ADDR_W-1:0]    set_addr;
  logic [ADDR_W-1:0]    rmw_addr;
  status_e              rec_stat;

  // scan and count
  logic [9:0]           tot_num;
  logic [19:0]          tot_prod;
  logic [7:0]           limit;
  logic                 scan_past;
  logic                 scan_fail;
  logic                 scan_done;
  logic [8:0]           cnt_full;
  logic [7:0]           cnt_sat;
  logic                 rd_in_range;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || out_o.ready;

  // record fields: data byte a, nibble b, check code, slot
  assign rec_a   = {req_q.rec_byte1[5], req_q.rec_byte2[6:0]};
  assign rec_b   = req_q.rec_byte3[3:0];
  assign slot    = req_q.rec_byte3[6:4];
  assign chk_ok  = (rec_a[4:0] ^ {1'b0, rec_b}) == req_q.rec_byte1[4:0];
  assign is_hdr  = (req_q.group_len == HEADER_GROUP) && (slot == HEADER_SLOT);
  // group zero gives a negative order unless the slot brings it back to zero
  assign grp_neg = (req_q.group_len == 8'd0) && (slot != HEADER_SLOT);
  // (group_len - 1) * 7 + slot as 8 * g - g + slot - 7
  assign ord_raw = ({4'b0, req_q.group_len} << 3) - {4'b0, req_q.group_len}
                 + {9'b0, slot} - 12'd7;
  assign order   = is_hdr ? '0 : ord_raw[ORDER_W-1:0];
  assign odd_ord = order[0];
  assign ord_p1  = {1'b0, order} + 12'd1;

  // even order o: bytes 3o/2 and +1; odd order: 3(o+1)/2 - 2 and +1
  always_comb begin
    if (odd_ord) begin
      lo_addr = {1'b0, ord_p1} + {2'b0, ord_p1[11:1]} - BADDR_W'(2);
    end else begin
      lo_addr = {2'b0, order} + {3'b0, order[ORDER_W-1:1]};
    end
  end

  assign hi_addr  = lo_addr + BADDR_W'(1);
  assign range_ok = hi_addr < BADDR_W'(BUFFER_BYTES);
  // even orders set the low byte and merge the nibble high; odd orders the reverse
  assign set_addr = odd_ord ? hi_addr[ADDR_W-1:0] : lo_addr[ADDR_W-1:0];
  assign rmw_addr = odd_ord ? lo_addr[ADDR_W-1:0] : hi_addr[ADDR_W-1:0];

  always_comb begin
    if (done_q) begin
      rec_stat = STAT_COMPLETE;
    end else if (!chk_ok) begin
      rec_stat = STAT_CHECK_FAIL;
    end else if (grp_neg || !range_ok) begin
      rec_stat = STAT_RANGE;
    end else begin
      rec_stat = STAT_OK;
    end
  end

  // orders needed: (2L + 2) / 3 by reciprocal multiply
  assign tot_num  = {1'b0, hdr_q, 1'b0} + 10'd2;
  assign tot_prod = tot_num * 10'(RECIP3);
  assign limit    = tot_q - 8'd1;

  // scan: address scan_q goes out while the map bit of scan_q - 1 comes back
  assign scan_past = ({5'b0, scan_q} >= BADDR_W'(BUFFER_BYTES)) && (scan_q < limit);
  assign scan_fail = (pend_q && !map_rdata) || scan_past;
  assign scan_done = !scan_fail && (scan_q == limit);

  // byte count 3T/2, plus one for odd T, saturated
  assign cnt_full = {1'b0, tot_q} + {2'b0, tot_q[7:1]} + {8'b0, tot_q[0]};
  assign cnt_sat  = cnt_full[8] ? COUNT_MAX : cnt_full[7:0];

  assign rd_in_range = {4'b0, req_q.read_index} < BADDR_W'(BUFFER_BYTES);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(BUFFER_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.data.cmd == CMD_READ) ? ST_RDREQ : ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = (rec_stat == STAT_OK) ? ST_MERGE : ST_RESP;
      end
      ST_MERGE: begin
        state_d = (hdr_q != 8'd0) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        if (scan_fail || scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RDREQ: state_d = ST_RDCAP;
      ST_RDCAP: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // sequencer outputs: ram ports and input ready
  always_comb begin
    pay_we     = 1'b0;
    pay_waddr  = clr_q;
    pay_wdata  = 8'd0;
    pay_raddr  = rmw_addr;
    map_we     = 1'b0;
    map_waddr  = clr_q;
    map_wdata  = 1'b0;
    map_raddr  = scan_q[ADDR_W-1:0];
    in_i.ready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        pay_we = 1'b1;
        map_we = 1'b1;
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ST_DECODE: begin
        if (rec_stat == STAT_OK) begin
          pay_we    = 1'b1;
          pay_waddr = set_addr;
          pay_wdata = rec_a;
          map_we    = 1'b1;
          map_waddr = order[ADDR_W-1:0];
          map_wdata = 1'b1;
        end
      end
      ST_MERGE: begin
        pay_we    = 1'b1;
        pay_waddr = rmw_addr_q;
        pay_wdata = pay_rdata | nib_q;
      end
      ST_RDREQ: begin
        pay_raddr = ADDR_W'(req_q.read_index);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      hdr_q    <= '0;
      bcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (state_q == ST_DECODE && rec_stat == STAT_OK && is_hdr) begin
        hdr_q <= rec_a;
      end
      if (state_q == ST_MERGE) begin
        scan_q <= '0;
        pend_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        scan_q <= scan_q + 8'd1;
        pend_q <= scan_q < limit;
        if (scan_done) begin
          done_q <= 1'b1;
          bcnt_q <= cnt_sat;
        end
      end
      if (state_q == ST_RESP && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= in_i.data;
      stat_q <= STAT_OK;
      rdat_q <= 8'd0;
    end
    if (state_q == ST_DECODE) begin
      stat_q     <= rec_stat;
      rmw_addr_q <= rmw_addr;
      nib_q      <= odd_ord ? {4'b0, rec_b} : {rec_b, 4'b0};
    end
    if (state_q == ST_MERGE) begin
      tot_q <= tot_prod[RECIP3_SH +: 8];
    end
    if (state_q == ST_RDCAP) begin
      rdat_q <= rd_in_range ? pay_rdata : 8'd0;
    end
    if (state_q == ST_RESP && out_free) begin
      odata_q.status        <= stat_q;
      odata_q.complete      <= done_q;
      odata_q.payload_bytes <= bcnt_q;
      odata_q.read_data     <= rdat_q;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

  mrr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  mrr_ram #(
    .WIDTH (1),
    .DEPTH (BUFFER_BYTES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // complete never drops once set
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> done_q)
    else $error("complete flag cleared");

  // a nonzero count only goes out with complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && (odata_q.payload_bytes != 8'd0) |-> odata_q.complete)
    else $error("byte count without complete");

  // read data only on ok results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && (odata_q.read_data != 8'd0) |-> odata_q.status == STAT_OK)
    else $error("read data on a record result");

  // the scan never runs past its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> scan_q <= limit)
    else $error("scan past limit");

endmodule

// ----- bench/tb_multicast_record_reassembler.sv -----
// tb_multicast_record_reassembler: self-checking bench for the record reassembler
// depends on mrr_pkg, mrr_in_if, mrr_out_if and the multicast_record_reassembler rtl
// beats are checked against a mirror of the payload store, received map and header
module tb_multicast_record_reassembler import mrr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // run limits: clearing pass plus all test beats with their stalls, several times over
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 250;
  // highest order whose two bytes still fit the buffer
  localparam int LAST_ORDER   = 340;
  localparam int ERR_PRINTS   = 40;

  logic clk_i;
  logic rst_ni;

  mrr_in_if  in_bus ();
  mrr_out_if out_bus ();

  multicast_record_reassembler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // mirror of the block state, all zero after the clearing pass
  bit [7:0] payload_mirror [BUFFER_BYTES];
  bit       got_order      [BUFFER_BYTES];
  bit [7:0] hdr_len;
  bit       asm_done;
  bit [7:0] asm_bytes;

  // responses still owed by the block, oldest first
  out_item_t due_responses [$];

  int err_cnt;
  int cycle_cnt;
  int burst_left;
  int n_stored, n_rejected, n_late, n_reads;

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
             due_responses.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_error(string msg);
    if (err_cnt < ERR_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // once a nonzero header length is known, all orders below total-1 must be in
  function automatic void scan_for_completion();
    int  total;
    int  cnt;
    int  i;
    bit  full;
    if (hdr_len == 8'd0) return;
    total = (int'(hdr_len) * 2 + 2) / 3;
    full  = 1'b1;
    for (i = 0; i + 1 < total; i++) begin
      // an order past the map counts as missing
      if (i >= BUFFER_BYTES || !got_order[i]) full = 1'b0;
    end
    if (!full) return;
    cnt = (total * 3) / 2 + (total % 2);
    if (cnt > int'(COUNT_MAX)) cnt = int'(COUNT_MAX);
    asm_done  = 1'b1;
    asm_bytes = cnt[7:0];
  endfunction

  // decode one record, update the mirror and return its status
  function automatic status_e absorb_record(in_item_t it);
    logic [7:0] a;
    logic [3:0] nib;
    logic [2:0] slot;
    bit         is_hdr;
    int         order;
    int         lo;
    int         hi;
    // nothing moves once the payload is complete
    if (asm_done) return STAT_COMPLETE;
    a    = {it.rec_byte1[5], it.rec_byte2[6:0]};
    nib  = it.rec_byte3[3:0];
    slot = it.rec_byte3[6:4];
    if ((a[4:0] ^ {1'b0, nib}) != it.rec_byte1[4:0]) return STAT_CHECK_FAIL;
    // group zero gives a negative order, except slot 7 which lands on order zero
    if (it.group_len == 8'd0 && slot != HEADER_SLOT) return STAT_RANGE;
    is_hdr = (it.group_len == HEADER_GROUP) && (slot == HEADER_SLOT);
    order  = is_hdr ? 0 : (int'(it.group_len) - 1) * 7 + int'(slot);
    // even orders start a byte triple, odd orders finish it
    lo = (order % 2 == 0) ? (order * 3) / 2 : ((order + 1) * 3) / 2 - 2;
    hi = lo + 1;
    if (hi >= BUFFER_BYTES) return STAT_RANGE;
    // a later header simply replaces the length
    if (is_hdr) hdr_len = a;
    got_order[order] = 1'b1;
    if (order % 2 == 0) begin
      payload_mirror[lo] = a;
      payload_mirror[hi] = payload_mirror[hi] | {nib, 4'h0};
    end else begin
      payload_mirror[lo] = payload_mirror[lo] | {4'h0, nib};
      payload_mirror[hi] = a;
    end
    scan_for_completion();
    return STAT_OK;
  endfunction

  function automatic out_item_t predict_response(in_item_t it);
    out_item_t r;
    r.read_data = 8'h00;
    if (it.cmd == CMD_READ) begin
      // record fields are don't-care on a read
      r.status = STAT_OK;
      if (it.read_index < BUFFER_BYTES) r.read_data = payload_mirror[it.read_index];
      n_reads++;
    end else begin
      r.status = absorb_record(it);
      case (r.status)
        STAT_OK:       n_stored++;
        STAT_COMPLETE: n_late++;
        default:       n_rejected++;
      endcase
    end
    r.complete      = asm_done;
    r.payload_bytes = asm_bytes;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // beat builders
  // ---------------------------------------------------------------------------

  // read beat with junk in the record fields
  function automatic in_item_t make_read(logic [8:0] idx);
    in_item_t it;
    it.cmd        = CMD_READ;
    it.rec_byte1  = 8'($urandom);
    it.rec_byte2  = 8'($urandom);
    it.rec_byte3  = 8'($urandom);
    it.group_len  = 8'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // record beat; unused bits are random, a bad check flips some code bits
  function automatic in_item_t make_record(logic [7:0] glen, logic [2:0] slot,
                                           logic [7:0] a, logic [3:0] nib, bit good);
    in_item_t   it;
    logic [4:0] code;
    code = a[4:0] ^ {1'b0, nib};
    if (!good) code = code ^ 5'($urandom_range(1, 31));
    it.cmd        = CMD_RECORD;
    it.rec_byte1  = {2'($urandom), a[7], code};
    it.rec_byte2  = {1'($urandom), a[6:0]};
    it.rec_byte3  = {1'($urandom), slot, nib};
    it.group_len  = glen;
    it.read_index = 9'($urandom);
    return it;
  endfunction

  // record for a given order, sometimes reached through the slot-7 alias
  function automatic in_item_t record_at(int order, bit good);
    logic [7:0] a;
    logic [3:0] nib;
    a   = 8'($urandom);
    nib = 4'($urandom);
    if (order >= 14 && order % 7 == 0 && $urandom_range(0, 1) == 1)
      return make_record(8'(order / 7), HEADER_SLOT, a, nib, good);
    return make_record(8'(order / 7 + 1), 3'(order % 7), a, nib, good);
  endfunction

  function automatic logic [8:0] pick_index();
    return ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 260));
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of beats with random gaps, valid held high inside a burst
  // ---------------------------------------------------------------------------
  task automatic send_beat(in_item_t it);
    int gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 4))
        0:       gap = 0;
        1:       gap = $urandom_range(8, 60);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    // ready is read before the edge's own updates land
    do @(posedge clk_i); while (!in_bus.ready);
    due_responses.push_back(predict_response(it));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: rotating stall pattern, reloaded now and then
  // ---------------------------------------------------------------------------
  initial begin : result_stall
    logic [15:0] pat;
    out_bus.ready = 1'b0;
    pat = 16'hFFFF;
    forever begin
      @(negedge clk_i);
      if (cycle_cnt % 96 == 0) begin
        // a quarter of the windows run with no stalls at all
        case ($urandom_range(0, 3))
          0:       pat = 16'hFFFF;
          default: pat = 16'($urandom) | 16'h0001;
        endcase
      end
      out_bus.ready <= pat[0];
      pat = {pat[0], pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = out_bus.data;
      if (due_responses.size() == 0) begin
        note_error($sformatf("result beat with nothing awaited (status %0d)", got.status));
      end else begin
        want = due_responses.pop_front();
        if (got.status !== want.status)
          note_error($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.complete !== want.complete)
          note_error($sformatf("complete %0b, expected %0b", got.complete, want.complete));
        if (got.payload_bytes !== want.payload_bytes)
          note_error($sformatf("payload_bytes %0d, expected %0d",
                               got.payload_bytes, want.payload_bytes));
        if (got.read_data !== want.read_data)
          note_error($sformatf("read_data 0x%02h, expected 0x%02h",
                               got.read_data, want.read_data));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // store must read back zero after the clearing pass
  task automatic test_reads_after_clear();
    send_beat(make_read(9'd0));
    send_beat(make_read(9'd511));
    send_beat(make_read(9'h155));
    send_beat(make_read(9'h0AA));
  endtask

  // bad check code, group zero and orders past the buffer leave no trace
  task automatic test_rejected_records();
    send_beat(make_record(8'd2, 3'd3, 8'hFF, 4'h0, 1'b0));
    send_beat(make_record(HEADER_GROUP, HEADER_SLOT, 8'h40, 4'h5, 1'b0));
    send_beat(make_record(8'd0, 3'd2, 8'h11, 4'h3, 1'b1));
    send_beat(make_record(8'd49, 3'd5, 8'hA5, 4'h6, 1'b1));
    send_beat(make_record(8'd255, 3'd7, 8'h00, 4'hF, 1'b1));
  endtask

  // the two highest orders that still fit land in the last buffer bytes
  task automatic test_buffer_edges();
    send_beat(make_record(8'd49, 3'd4, 8'hFF, 4'hF, 1'b1));
    send_beat(make_record(8'd49, 3'd3, 8'h00, 4'hA, 1'b1));
    send_beat(make_read(9'd508));
    send_beat(make_read(9'd509));
    send_beat(make_read(9'd510));
    send_beat(make_read(9'd511));
  endtask

  // order zero written twice, once as a header of length zero, then order one
  task automatic test_empty_header();
    send_beat(make_record(8'd1, 3'd0, 8'h80, 4'h6, 1'b1));
    send_beat(make_record(HEADER_GROUP, HEADER_SLOT, 8'h00, 4'h9, 1'b1));
    send_beat(make_record(8'd1, 3'd1, 8'h7F, 4'hC, 1'b1));
    send_beat(make_read(9'd0));
    send_beat(make_read(9'd1));
    send_beat(make_read(9'd2));
  endtask

  // records scattered over the whole buffer with no length known yet
  task automatic test_random_scatter(int beats);
    logic [7:0] glen;
    repeat (beats) begin
      case ($urandom_range(0, 9))
        0, 1: send_beat(make_read(9'($urandom)));
        2:    send_beat(make_record(8'($urandom), 3'($urandom), 8'($urandom),
                                    4'($urandom), 1'b0));
        3: begin
          // group zero or far past the buffer; group zero with slot 7 lands on order zero
          glen = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(50, 255));
          send_beat(make_record(glen, 3'($urandom), 8'($urandom), 4'($urandom), 1'b1));
        end
        default: send_beat(record_at($urandom_range(1, LAST_ORDER), 1'b1));
      endcase
    end
  endtask

  // header, then every needed order in shuffled order mixed with noise;
  // the header is replaced half way, completion comes at the latest on the last needed order
  task automatic test_random_assembly();
    int         need [$];
    int         first_len;
    int         last_len;
    int         total;
    int         k;
    int         j;
    int         tmp;
    bit         swapped;
    first_len = $urandom_range(100, 255);
    last_len  = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(150, 254);
    total     = (((first_len > last_len) ? first_len : last_len) * 2 + 2) / 3;
    for (k = 1; k + 1 < total; k++) need.push_back(k);
    for (k = need.size() - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = need[k];
      need[k] = need[j];
      need[j] = tmp;
    end
    send_beat(make_record(HEADER_GROUP, HEADER_SLOT, 8'(first_len), 4'($urandom), 1'b1));
    swapped = 1'b0;
    k = 0;
    while (k < need.size()) begin
      if (!swapped && k >= need.size() / 2) begin
        send_beat(make_record(HEADER_GROUP, HEADER_SLOT, 8'(last_len), 4'($urandom), 1'b1));
        swapped = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: send_beat(make_read(pick_index()));
        1: send_beat(record_at($urandom_range(1, total), 1'b0));
        // rewrite of an order inside the payload, or anything up to past the end
        2: send_beat(record_at($urandom_range(0, 1) == 1 ?
                               $urandom_range(1, total) : $urandom_range(1, 345), 1'b1));
        default: begin
          send_beat(record_at(need[k], 1'b1));
          k++;
        end
      endcase
    end
  endtask

  // after completion records bounce and the store reads back unchanged
  task automatic test_after_complete(int beats);
    send_beat(make_record(HEADER_GROUP, HEADER_SLOT, 8'h10, 4'h3, 1'b1));
    repeat (beats) begin
      if ($urandom_range(0, 1) == 1) send_beat(make_read(pick_index()));
      else send_beat(record_at($urandom_range(0, 345), 1'($urandom)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni       = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first beat waits out the clearing pass through ready
    test_reads_after_clear();
    test_rejected_records();
    test_buffer_edges();
    test_empty_header();
    test_random_scatter(120);
    test_random_assembly();
    test_after_complete(40);

    in_bus.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("beats: %0d stored, %0d rejected, %0d refused as complete, %0d reads",
             n_stored, n_rejected, n_late, n_reads);
    $display("assembly complete=%0b with header length %0d, byte count %0d, %0d cycles",
             asm_done, hdr_len, asm_bytes, cycle_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mrr_pkg.sv
rtl/mrr_if.sv
rtl/mrr_ram.sv
rtl/multicast_record_reassembler.sv
bench/tb_multicast_record_reassembler.sv
